>>> hw/rtl/bpa_pkg.sv
package bpa_pkg;

  // header layout of a 24-bit BMP file
  localparam logic [5:0] HEADER_BYTES = 6'd54;
  localparam logic [5:0] OFS_WIDTH    = 6'd18;
  localparam logic [5:0] OFS_HEIGHT   = 6'd22;
  localparam logic [5:0] OFS_DEPTH    = 6'd28;
  localparam logic [7:0] DEPTH_24     = 8'd24;

  // luma weights (x10000) and level step
  localparam int          LUMA_W_R  = 2126;
  localparam int          LUMA_W_G  = 7152;
  localparam int          LUMA_W_B  = 722;
  localparam int          LUMA_DIV  = 127500;
  localparam int          SUM_W     = 22;
  localparam logic [4:0]  LEVEL_MAX = 5'd19;

  // queue between the parser and the luma pipeline
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // one decoded pixel, as handed from parser to luma pipeline
  typedef struct packed {
    logic [11:0] x;
    logic [11:0] y;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic        err;
    logic        last;
  } pix_t;

  // level = min(floor(sum / LUMA_DIV), 19) by threshold compares
  function automatic logic [4:0] luma_level(input logic [SUM_W-1:0] sum);
    logic [4:0] lvl;
    lvl = 5'd0;
    for (int k = 1; k <= 19; k++) begin
      if (sum >= SUM_W'(k * LUMA_DIV)) lvl = lvl + 5'd1;
    end
    return lvl;
  endfunction

  // ramp from dark to bright
  function automatic logic [6:0] ramp_glyph(input logic [4:0] lvl);
    logic [6:0] g;
    unique case (lvl)
      5'd0:    g = 7'd64;   // @
      5'd1:    g = 7'd35;   // #
      5'd2:    g = 7'd36;   // $
      5'd3:    g = 7'd38;   // &
      5'd4:    g = 7'd37;   // %
      5'd5:    g = 7'd56;   // 8
      5'd6:    g = 7'd111;  // o
      5'd7:    g = 7'd43;   // +
      5'd8:    g = 7'd61;   // =
      5'd9:    g = 7'd124;  // |
      5'd10:   g = 7'd47;   // /
      5'd11:   g = 7'd105;  // i
      5'd12:   g = 7'd33;   // !
      5'd13:   g = 7'd58;   // :
      5'd14:   g = 7'd45;   // -
      5'd15:   g = 7'd42;   // *
      5'd16:   g = 7'd44;   // ,
      5'd17:   g = 7'd46;   // .
      5'd18:   g = 7'd39;   // '
      default: g = 7'd32;   // space
    endcase
    return g;
  endfunction

endpackage

>>> hw/rtl/bpa_front.sv
module bpa_front #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             new_file,
  input  logic [7:0]       data_byte,
  input  logic             q_full,
  output logic             push,
  output bpa_pkg::pix_t    push_data
);
  import bpa_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 1);

  logic [5:0]    bp, bp_next;
  logic [31:0]   img_w, img_w_next;
  logic [31:0]   img_h, img_h_next;
  logic          err, err_next;
  logic [1:0]    ch, ch_next;
  logic [7:0]    bhold, bhold_next;
  logic [7:0]    ghold, ghold_next;
  logic [CW-1:0] col, col_next;
  logic [RW-1:0] row, row_next;
  logic [1:0]    pad, pad_next;
  logic          done, done_next;
  logic          accept;
  logic          pix_fire;
  logic          last_pix;

  // stall only while the queue has no room
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // header parse and pixel walk for one byte
  always_comb begin
    bp_next    = bp;
    img_w_next = img_w;
    img_h_next = img_h;
    err_next   = err;
    ch_next    = ch;
    bhold_next = bhold;
    ghold_next = ghold;
    col_next   = col;
    row_next   = row;
    pad_next   = pad;
    done_next  = done;
    pix_fire   = 1'b0;
    last_pix   = 1'b0;

    if (new_file) begin
      bp_next    = '0;
      img_w_next = '0;
      img_h_next = '0;
      ch_next    = '0;
      bhold_next = '0;
      ghold_next = '0;
      col_next   = '0;
      row_next   = '0;
      pad_next   = '0;
      done_next  = 1'b0;
    end

    if (bp_next < HEADER_BYTES) begin
      unique case (bp_next)
        OFS_WIDTH:          img_w_next[7:0]   = data_byte;
        OFS_WIDTH + 6'd1:   img_w_next[15:8]  = data_byte;
        OFS_WIDTH + 6'd2:   img_w_next[23:16] = data_byte;
        OFS_WIDTH + 6'd3:   img_w_next[31:24] = data_byte;
        OFS_HEIGHT:         img_h_next[7:0]   = data_byte;
        OFS_HEIGHT + 6'd1:  img_h_next[15:8]  = data_byte;
        OFS_HEIGHT + 6'd2:  img_h_next[23:16] = data_byte;
        OFS_HEIGHT + 6'd3:  img_h_next[31:24] = data_byte;
        OFS_DEPTH:          if (data_byte != DEPTH_24) err_next = 1'b1;
        default:            ;
      endcase
      bp_next = bp_next + 6'd1;
      if (bp_next == HEADER_BYTES) begin
        ch_next  = '0;
        col_next = '0;
        row_next = '0;
        pad_next = '0;
        if (img_w_next > 32'(MAX_WIDTH) || img_h_next > 32'(MAX_HEIGHT)) begin
          err_next  = 1'b1;
          done_next = 1'b1;
        end else if (img_w_next == 32'd0 || img_h_next == 32'd0) begin
          done_next = 1'b1;
        end
      end
    end else if (done_next) begin
      // trailing bytes: nothing to do
    end else if (pad_next != 2'd0) begin
      pad_next = pad_next - 2'd1;
    end else if (ch_next == 2'd0) begin
      bhold_next = data_byte;
      ch_next    = 2'd1;
    end else if (ch_next == 2'd1) begin
      ghold_next = data_byte;
      ch_next    = 2'd2;
    end else begin
      // red byte completes the pixel
      pix_fire = 1'b1;
      ch_next  = 2'd0;
      last_pix = (32'(col_next) + 32'd1 == img_w_next) &&
                 (32'(row_next) + 32'd1 == img_h_next);
      col_next = col_next + CW'(1);
      if (32'(col_next) >= img_w_next) begin
        col_next = '0;
        row_next = row_next + RW'(1);
        pad_next = img_w_next[1:0];
        if (32'(row_next) >= img_h_next) done_next = 1'b1;
      end
    end
  end

  // pixel record to the queue
  assign push           = accept && pix_fire;
  assign push_data.x    = 12'(new_file ? '0 : col);
  assign push_data.y    = 12'(new_file ? '0 : row);
  assign push_data.r    = data_byte;
  assign push_data.g    = ghold;
  assign push_data.b    = bhold;
  assign push_data.err  = err_next;
  assign push_data.last = last_pix;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      bp    <= '0;
      img_w <= '0;
      img_h <= '0;
      err   <= 1'b0;
      ch    <= '0;
      col   <= '0;
      row   <= '0;
      pad   <= '0;
      done  <= 1'b0;
    end else if (accept) begin
      bp    <= bp_next;
      img_w <= img_w_next;
      img_h <= img_h_next;
      err   <= err_next;
      ch    <= ch_next;
      col   <= col_next;
      row   <= row_next;
      pad   <= pad_next;
      done  <= done_next;
    end
  end

  // held channels
  always_ff @(posedge clk) begin
    if (accept) begin
      bhold <= bhold_next;
      ghold <= ghold_next;
    end
  end

endmodule

>>> hw/rtl/bpa_queue.sv
module bpa_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  bpa_pkg::pix_t push_data,
  input  logic          pop,
  output bpa_pkg::pix_t pop_data,
  output logic          empty,
  output logic          full
);
  import bpa_pkg::*;

  pix_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign empty    = (count == '0);
  assign full     = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign pop_data = mem[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      unique case ({push, pop})
        2'b10:   count <= count + (QPTR_W + 1)'(1);
        2'b01:   count <= count - (QPTR_W + 1)'(1);
        default: ;
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

endmodule

>>> hw/rtl/bpa_back.sv
module bpa_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  input  bpa_pkg::pix_t q_data,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [11:0]   pix_x,
  output logic [11:0]   pix_y,
  output logic [7:0]    red,
  output logic [7:0]    green,
  output logic [7:0]    blue,
  output logic [4:0]    level,
  output logic [6:0]    glyph,
  output logic          format_error,
  output logic          last_pixel
);
  import bpa_pkg::*;

  logic             a_valid;
  pix_t             a_pix;
  logic [SUM_W-1:0] a_sum;
  logic [SUM_W-1:0] sum_c;
  logic [4:0]       lvl_c;
  logic             a_load;
  logic             b_load;

  // stage loads when empty or when its contents move on
  assign b_load = !out_valid || !out_stall;
  assign a_load = !a_valid || b_load;
  assign pop    = a_load && !q_empty;

  // weighted sum of the three channels
  assign sum_c = SUM_W'(LUMA_W_R) * SUM_W'(q_data.r)
               + SUM_W'(LUMA_W_G) * SUM_W'(q_data.g)
               + SUM_W'(LUMA_W_B) * SUM_W'(q_data.b);

  assign lvl_c = luma_level(a_sum);

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (a_load) a_valid   <= !q_empty;
      if (b_load) out_valid <= a_valid;
    end
  end

  // sum stage and output register
  always_ff @(posedge clk) begin
    if (a_load) begin
      a_pix <= q_data;
      a_sum <= sum_c;
    end
    if (b_load) begin
      pix_x        <= a_pix.x;
      pix_y        <= a_pix.y;
      red          <= a_pix.r;
      green        <= a_pix.g;
      blue         <= a_pix.b;
      level        <= lvl_c;
      glyph        <= ramp_glyph(lvl_c);
      format_error <= a_pix.err;
      last_pixel   <= a_pix.last;
    end
  end

endmodule

>>> hw/rtl/bmp24_pixel_to_ascii_level_core.sv
// Turns a 24-bit BMP byte stream into one item per pixel: position, the
// three channels, a luma level 0..19 and its ASCII ramp glyph. One byte is
// taken every cycle while in_stall is low; the 54 header bytes, row padding
// and blue/green bytes give no item. The item for a red byte reaches the
// outputs through the queue, which is written on the accepting edge, then
// the luma sum stage and then the level/glyph output register. A four-entry
// queue sits between the parser and the luma pipeline, so the input stalls
// only once the output has been stalled long enough to fill it.
// format_error is sticky until reset; a size above MAX_WIDTH x MAX_HEIGHT
// yields no pixels.
module bmp24_pixel_to_ascii_level_core #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        new_file,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] pix_x,
  output logic [11:0] pix_y,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic [4:0]  level,
  output logic [6:0]  glyph,
  output logic        format_error,
  output logic        last_pixel
);
  import bpa_pkg::*;

  logic q_full;
  logic q_empty;
  logic q_push;
  logic q_pop;
  pix_t q_in;
  pix_t q_out;

  // byte parser
  bpa_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .new_file  (new_file),
    .data_byte (data_byte),
    .q_full    (q_full),
    .push      (q_push),
    .push_data (q_in)
  );

  // pixel queue
  bpa_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty),
    .full      (q_full)
  );

  // luma pipeline
  bpa_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_data       (q_out),
    .pop          (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pix_x        (pix_x),
    .pix_y        (pix_y),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .level        (level),
    .glyph        (glyph),
    .format_error (format_error),
    .last_pixel   (last_pixel)
  );

  // checks
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> level <= LEVEL_MAX)
    else $error("level out of range");

  a_glyph_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> glyph == ramp_glyph(level))
    else $error("glyph does not match level");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("pixel queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("pixel queue underflow");

endmodule
